>>> design/lgc_pkg.sv
// ----------------------------------------------------------------------------
// lgc_pkg: shared types and constants of the glyph cache tag engine
// Holds field widths, status codes, the sequencer state type and the
// structs that pass between the slot store, the compare unit and the top.
// ----------------------------------------------------------------------------
package lgc_pkg;

  // Default sizes of the cache and of the glyph backing store.
  localparam int unsigned SlotsDefault      = 64;
  localparam int unsigned GlyphCountDefault = 24192;
  localparam int unsigned GlyphBytesDefault = 98;

  // Fixed field widths.
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned OFF_W      = 22;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_HIT    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FLUSH  = 2'd3;

  // Request type codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_RESP
  } lgc_state_e;

  // One slot as seen by the compare unit.
  typedef struct packed {
    logic            valid;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  ts;
  } lgc_rd_t;

  // One write into the slot store.
  typedef struct packed {
    logic             tag_we;
    logic             ts_we;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  ts;
  } lgc_wr_t;

endpackage

>>> design/lgc_slot_store.sv
// ----------------------------------------------------------------------------
// lgc_slot_store: tag and timestamp storage of the glyph cache
// Tags and timestamps sit in memories with one write port and one registered
// read port. Valid and stale bits are flip-flops, so a flush and a clock wrap
// take effect on every slot at once.
// ----------------------------------------------------------------------------
module lgc_slot_store #(
  parameter int unsigned Slots = lgc_pkg::SlotsDefault,
  localparam int unsigned SlotW = $clog2(Slots)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SlotW-1:0] rd_addr_i,
  output lgc_pkg::lgc_rd_t rd_o,
  input  logic [SlotW-1:0] wr_addr_i,
  input  lgc_pkg::lgc_wr_t wr_i,
  input  logic             flush_i,
  input  logic             wrap_i
);

  logic [lgc_pkg::TAG_W-1:0] tag_mem [Slots];
  logic [lgc_pkg::TS_W-1:0]  ts_mem  [Slots];
  logic [Slots-1:0]          valid_q;
  logic [Slots-1:0]          stale_q;
  logic [lgc_pkg::TAG_W-1:0] tag_rd_q;
  logic [lgc_pkg::TS_W-1:0]  ts_rd_q;
  logic [SlotW-1:0]          rd_addr_q;

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.tag_we) begin
      tag_mem[wr_addr_i] <= wr_i.tag;
    end
    if (wr_i.ts_we) begin
      ts_mem[wr_addr_i] <= wr_i.ts;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    tag_rd_q  <= tag_mem[rd_addr_i];
    ts_rd_q   <= ts_mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  // Valid bits: a fill sets one, a flush clears all.
  // Stale bits: a wrap marks every timestamp as zero until it is rewritten.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      stale_q <= '0;
    end else begin
      if (flush_i) begin
        valid_q <= '0;
      end else if (wr_i.tag_we) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (wrap_i) begin
        stale_q <= '1;
      end else if (wr_i.ts_we) begin
        stale_q[wr_addr_i] <= 1'b0;
      end
    end
  end

  // A stale timestamp reads as zero.
  always_comb begin
    rd_o.valid = valid_q[rd_addr_q];
    rd_o.tag   = tag_rd_q;
    rd_o.ts    = stale_q[rd_addr_q] ? '0 : ts_rd_q;
  end

endmodule

>>> design/lgc_victim_sel.sv
// ----------------------------------------------------------------------------
// lgc_victim_sel: shared compare unit of the slot scan
// Checks one slot a cycle while stepped for a tag hit, tracks the first empty
// slot and the valid slot with the smallest timestamp, lowest index on ties.
// ----------------------------------------------------------------------------
module lgc_victim_sel #(
  parameter int unsigned Slots = lgc_pkg::SlotsDefault,
  localparam int unsigned SlotW = $clog2(Slots)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      step_i,
  input  logic [SlotW-1:0]          idx_i,
  input  lgc_pkg::lgc_rd_t          rd_i,
  input  logic [lgc_pkg::TAG_W-1:0] code_i,
  output logic                      hit_o,
  output logic [SlotW-1:0]          victim_o
);

  logic                     have_empty_q;
  logic [SlotW-1:0]         empty_idx_q;
  logic                     have_old_q;
  logic [lgc_pkg::TS_W-1:0] old_ts_q;
  logic [SlotW-1:0]         old_idx_q;

  // Tag match on the slot under test.
  assign hit_o = step_i && rd_i.valid && (rd_i.tag == code_i);

  // An empty slot beats the oldest valid one.
  assign victim_o = have_empty_q ? empty_idx_q : old_idx_q;

  // Candidate tracking; strict compare keeps the lowest index on ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_empty_q <= 1'b0;
      have_old_q   <= 1'b0;
    end else if (clear_i) begin
      have_empty_q <= 1'b0;
      have_old_q   <= 1'b0;
    end else if (step_i && !hit_o) begin
      if (!rd_i.valid) begin
        if (!have_empty_q) begin
          have_empty_q <= 1'b1;
        end
      end else if (!have_old_q || (rd_i.ts < old_ts_q)) begin
        have_old_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !hit_o && !clear_i) begin
      if (!rd_i.valid) begin
        if (!have_empty_q) begin
          empty_idx_q <= idx_i;
        end
      end else if (!have_old_q || (rd_i.ts < old_ts_q)) begin
        old_ts_q  <= rd_i.ts;
        old_idx_q <= idx_i;
      end
    end
  end

endmodule

>>> design/lru_glyph_cache_tags.sv
// Lookup: the scan reads one slot a cycle through the single tag/timestamp
// memory read port; a hit ends the scan, a miss scans every slot and then
// fills the victim. Flush and rejected lookups go straight to the response.
// One item is in work at a time; the next is taken in the cycle after the word
// is loaded into the output register.
// Reset clears valid bits, the use clock and font_ready at once, no clear pass.
// ----------------------------------------------------------------------------
// lru_glyph_cache_tags: tag and LRU replacement engine of a glyph cache
// Fully associative cache with timestamp LRU. A sequencer drives a slot scan
// through one shared compare unit and on a miss fills the chosen victim slot.
// ----------------------------------------------------------------------------
module lru_glyph_cache_tags #(
  parameter int unsigned SLOTS       = lgc_pkg::SlotsDefault,
  parameter int unsigned GLYPH_COUNT = lgc_pkg::GlyphCountDefault,
  parameter int unsigned GLYPH_BYTES = lgc_pkg::GlyphBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_font_ready_i,
  // Request channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [lgc_pkg::TAG_W-1:0]      glyph_code_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lgc_pkg::STATUS_W-1:0]   status_o,
  output logic [lgc_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic [lgc_pkg::OFF_W-1:0]      fetch_offset_o
);

  localparam int unsigned SlotW  = $clog2(SLOTS);
  localparam int unsigned BytesW = $clog2(GLYPH_BYTES + 1);
  localparam int unsigned ProdW  = lgc_pkg::TAG_W + BytesW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

  lgc_pkg::lgc_state_e state_q, state_d;

  logic                           font_ready_q;
  logic [lgc_pkg::TS_W-1:0]       use_clock_q, use_clock_d;
  logic [lgc_pkg::TS_W-1:0]       tick_inc;
  logic [lgc_pkg::TAG_W-1:0]      code_q, code_d;
  logic [SlotW-1:0]               rd_idx_q, rd_idx_d;
  logic [SlotW-1:0]               cmp_idx_q, cmp_idx_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic                           issue_q, issue_d;
  logic [lgc_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic [lgc_pkg::SLOT_OUT_W-1:0] res_slot_q, res_slot_d;
  logic [lgc_pkg::OFF_W-1:0]      res_off_q, res_off_d;
  logic                           out_valid_q;
  logic [lgc_pkg::STATUS_W-1:0]   out_status_q;
  logic [lgc_pkg::SLOT_OUT_W-1:0] out_slot_q;
  logic [lgc_pkg::OFF_W-1:0]      out_off_q;
  logic                           out_load;
  logic                           flush;
  logic                           wrap;
  logic                           sel_clear;
  logic                           hit;
  logic [SlotW-1:0]               victim;
  logic [SlotW-1:0]               wr_addr;
  logic [ProdW-1:0]               prod;
  lgc_pkg::lgc_wr_t               wr;
  lgc_pkg::lgc_rd_t               rd;

  // Slot storage.
  lgc_slot_store #(
    .Slots(SLOTS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_idx_q),
    .rd_o     (rd),
    .wr_addr_i(wr_addr),
    .wr_i     (wr),
    .flush_i  (flush),
    .wrap_i   (wrap)
  );

  // Shared compare unit.
  lgc_victim_sel #(
    .Slots(SLOTS)
  ) u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (sel_clear),
    .step_i  (cmp_vld_q),
    .idx_i   (cmp_idx_q),
    .rd_i    (rd),
    .code_i  (code_q),
    .hit_o   (hit),
    .victim_o(victim)
  );

  // Byte offset of the glyph in the backing store.
  assign prod     = ProdW'(code_q) * ProdW'(GLYPH_BYTES);
  assign tick_inc = use_clock_q + 1'b1;

  // Configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  // Sequencer next state and controls.
  always_comb begin
    state_d      = state_q;
    use_clock_d  = use_clock_q;
    code_d       = code_q;
    rd_idx_d     = rd_idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    issue_d      = issue_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_off_d    = res_off_q;
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    flush        = 1'b0;
    wrap         = 1'b0;
    sel_clear    = 1'b0;
    wr_addr      = cmp_idx_q;
    wr           = '0;
    wr.tag       = code_q;
    wr.ts        = use_clock_q;
    case (state_q)
      lgc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_slot_d = '0;
          res_off_d  = '0;
          if (req_type_i == lgc_pkg::REQ_FLUSH) begin
            flush        = 1'b1;
            use_clock_d  = '0;
            res_status_d = lgc_pkg::STAT_FLUSH;
            state_d      = lgc_pkg::ST_RESP;
          end else if (!font_ready_q ||
                       (glyph_code_i >= lgc_pkg::TAG_W'(GLYPH_COUNT))) begin
            res_status_d = lgc_pkg::STAT_REJECT;
            state_d      = lgc_pkg::ST_RESP;
          end else begin
            if (tick_inc == '0) begin
              wrap        = 1'b1;
              use_clock_d = lgc_pkg::TS_W'(1);
            end else begin
              use_clock_d = tick_inc;
            end
            code_d    = glyph_code_i;
            sel_clear = 1'b1;
            rd_idx_d  = '0;
            issue_d   = 1'b1;
            state_d   = lgc_pkg::ST_SCAN;
          end
        end
      end
      lgc_pkg::ST_SCAN: begin
        // Issue one read a cycle; compare the slot read in the previous cycle.
        if (issue_q) begin
          cmp_idx_d = rd_idx_q;
          cmp_vld_d = 1'b1;
          if (rd_idx_q == LastSlot) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (hit) begin
          wr.ts_we     = 1'b1;
          cmp_vld_d    = 1'b0;
          issue_d      = 1'b0;
          res_status_d = lgc_pkg::STAT_HIT;
          res_slot_d   = lgc_pkg::SLOT_OUT_W'(cmp_idx_q);
          state_d      = lgc_pkg::ST_RESP;
        end else if (cmp_vld_q && (cmp_idx_q == LastSlot)) begin
          state_d = lgc_pkg::ST_FILL;
        end
      end
      lgc_pkg::ST_FILL: begin
        // Take the victim slot for the new code.
        wr_addr      = victim;
        wr.tag_we    = 1'b1;
        wr.ts_we     = 1'b1;
        res_status_d = lgc_pkg::STAT_MISS;
        res_slot_d   = lgc_pkg::SLOT_OUT_W'(victim);
        res_off_d    = lgc_pkg::OFF_W'(prod);
        state_d      = lgc_pkg::ST_RESP;
      end
      lgc_pkg::ST_RESP: begin
        // Hand the result word to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = lgc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lgc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lgc_pkg::ST_IDLE;
      font_ready_q <= 1'b0;
      use_clock_q  <= '0;
      issue_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      use_clock_q <= use_clock_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      if (cfg_valid_i) begin
        font_ready_q <= cfg_font_ready_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    code_q       <= code_d;
    rd_idx_q     <= rd_idx_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_off_q    <= res_off_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_off_q    <= res_off_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_o         = out_slot_q;
  assign fetch_offset_o = out_off_q;

  // A scan always runs with a nonzero use clock, also right after a wrap.
  a_clock_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgc_pkg::ST_SCAN) |-> (use_clock_q != '0))
    else $error("use clock is zero during a scan");

  // The fill step is only reached from a complete scan without a hit.
  a_fill_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgc_pkg::ST_FILL) |-> ($past(state_q) == lgc_pkg::ST_SCAN))
    else $error("fill entered without a scan");

  // Rejected and flush words carry no slot and no offset.
  a_empty_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == lgc_pkg::STAT_REJECT ||
                     out_status_q == lgc_pkg::STAT_FLUSH))
    |-> (out_slot_q == '0 && out_off_q == '0))
    else $error("reject or flush word with nonzero fields");

  // A hit word never carries a fetch offset.
  a_hit_no_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == lgc_pkg::STAT_HIT) |-> (out_off_q == '0))
    else $error("hit word with a fetch offset");

endmodule
